// File: src/ssd_bm_pkg.sv
// Shared types and constants for the SSD stereo block matcher.
package ssd_bm_pkg;

	localparam int PIX_W   = 8;
	localparam int COL_W   = 3 * PIX_W;
	localparam int CNT_W   = 9;
	localparam int WIDTH_W = 9;
	localparam int SRCH_W  = 6;
	localparam int DISP_W  = 6;
	localparam int XCOL_W  = 8;
	localparam int SQ_W    = 2 * PIX_W;
	localparam int SCORE_W = SQ_W + 4;
	localparam int CAND_W  = 6;
	localparam int FETCH_W = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	// Fixed limits of the band geometry
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_SEARCH = 60;

	localparam logic [CNT_W-1:0]   COUNT_MAX    = 9'd511;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 9'd256;
	localparam logic [SRCH_W-1:0]  SEARCH_RESET = 6'd60;
	localparam logic [WIDTH_W-1:0] WIDTH_MIN    = 9'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} ssd_state_t;

endpackage

// File: src/stereo_ssd_block_match_core.sv
// Top level of the 3x3 SSD stereo block matcher with its shared scoring unit.
//
// Usage: the input channel (in_valid/in_ready) carries one image column per
// word: three reference pixels, three matched pixels and first_column, which
// restarts the column count at zero. After column c (2 <= c <= width-2) the
// block scores reference column x = c-2 against every right column s from
// max(0, x-search) to x and returns one word on the output channel
// (out_valid/out_ready): x-s of the best match, x, and last_in_row. A column
// with no result is taken and in_ready stays high.
// in_ready stays low while a column with a result is scored, so the block
// takes no new column before it is through with the last. One right column
// is read from the ring memory and one candidate is scored by a single 3x3
// square-and-sum unit per cycle. The output word sits in its own register,
// so the next column is taken while a result waits; a stalled receiver holds
// the block only once a second result is ready.
// Reset (arst_n low) clears the column count, the sequencer and the output
// valid, and sets the row width to 256 and the search to 60. The ring memory
// is not cleared; a band fed in order reads only columns it wrote.
// Write configuration (cfg_we) only while the block is idle.
module stereo_ssd_block_match_core
	import ssd_bm_pkg::*;
#(
	parameter int RING_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input column words
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIX_W-1:0]      left_top,
	input  logic [PIX_W-1:0]      left_mid,
	input  logic [PIX_W-1:0]      left_bottom,
	input  logic [PIX_W-1:0]      right_top,
	input  logic [PIX_W-1:0]      right_mid,
	input  logic [PIX_W-1:0]      right_bottom,
	input  logic                  first_column,
	// result words
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DISP_W-1:0]     disparity,
	output logic [XCOL_W-1:0]     column,
	output logic                  last_in_row
);

	localparam int RW = $clog2(RING_DEPTH);
	// Search is capped so the ring never wraps onto a column still needed
	localparam int SCAP0 = (MAX_SEARCH < RING_DEPTH - 3) ? MAX_SEARCH : RING_DEPTH - 3;
	localparam int SCAP  = (SCAP0 > 63) ? 63 : SCAP0;
	localparam int WCAP  = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;

	// Configuration registers
	logic [WIDTH_W-1:0] row_width_q;
	logic [SRCH_W-1:0]  max_search_q;

	// Column bookkeeping
	logic [CNT_W-1:0] cnt_q;
	logic [RW-1:0]    wp_q;
	logic [COL_W-1:0] lw_q [3];

	// Sequencer
	ssd_state_t         state_q, state_d;
	logic [RW-1:0]      rd_addr_q;
	logic [FETCH_W-1:0] fetch_left_q;
	logic [CAND_W-1:0]  nm1_q;
	logic [CAND_W-1:0]  cand_q;
	logic [XCOL_W-1:0]  xcol_q;
	logic               xlast_q;

	// Scoring pipeline
	logic [COL_W-1:0]   ring_mem [RING_DEPTH];
	logic               rv_s1;
	logic [COL_W-1:0]   rdata_s1;
	logic [COL_W-1:0]   win_q [2];
	logic [1:0]         fill_q;
	logic               sqv_s2;
	logic [SQ_W-1:0]    sq_s2 [9];
	logic               sv_s3;
	logic [SCORE_W-1:0] sum_s3;
	logic [SCORE_W-1:0] best_q;
	logic [CAND_W-1:0]  best_idx_q;

	// Output register
	logic               out_valid_q;
	logic [DISP_W-1:0]  disp_q;
	logic [XCOL_W-1:0]  col_q;
	logic               last_q;

	// Control strobes
	logic               accept;
	logic               fetch_en;
	logic               load_out;
	logic               last_cand;
	logic               win_full;

	// Per-column decode
	logic [CNT_W-1:0]   c_cur;
	logic [RW-1:0]      wp_cur;
	logic [WIDTH_W-1:0] w_eff;
	logic [SRCH_W-1:0]  sr_eff;
	logic               has_result;
	logic [CNT_W-1:0]   x_cur;
	logic [CAND_W-1:0]  nm1_cur;
	logic [RW-1:0]      back_off;
	logic [RW-1:0]      start_addr;

	// Scoring unit
	logic [COL_W-1:0]   rc [3];
	logic [SQ_W-1:0]    sq [9];
	logic [SCORE_W-1:0] sum;

	assign accept    = in_valid && in_ready;
	assign last_cand = sv_s3 && (cand_q == nm1_q);
	assign win_full  = rv_s1 && (fill_q >= 2'd2);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && has_result)
					state_d = ST_RUN;
			end
			ST_RUN: begin
				if (last_cand)
					state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (!out_valid_q || out_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		fetch_en = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_RUN:  fetch_en = (fetch_left_q != '0);
			ST_HOLD: load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// Decode the arriving column: position, effective width and search
	always_comb begin
		c_cur  = first_column ? '0 : cnt_q;
		wp_cur = first_column ? '0 : wp_q;

		w_eff = row_width_q;
		if (w_eff < WIDTH_MIN)
			w_eff = WIDTH_MIN;
		if (w_eff > WIDTH_W'(WCAP))
			w_eff = WIDTH_W'(WCAP);

		sr_eff = max_search_q;
		if (sr_eff > SRCH_W'(SCAP))
			sr_eff = SRCH_W'(SCAP);

		has_result = (c_cur >= CNT_W'(2)) && (c_cur <= w_eff - WIDTH_W'(2));
		x_cur      = c_cur - CNT_W'(2);
		nm1_cur    = (x_cur > CNT_W'(sr_eff)) ? sr_eff : CAND_W'(x_cur);

		// Ring slot of the lowest candidate: back off nm1+2 from column c
		back_off = RW'(nm1_cur) + RW'(2);
		if (wp_cur >= back_off)
			start_addr = wp_cur - back_off;
		else
			start_addr = RW'((RW+1)'(wp_cur) + (RW+1)'(RING_DEPTH) - (RW+1)'(back_off));
	end

	// Ring memory: write on accept, one registered read per cycle
	always_ff @(posedge clk) begin
		if (accept)
			ring_mem[wp_cur] <= {right_bottom, right_mid, right_top};
		if (fetch_en)
			rdata_s1 <= ring_mem[rd_addr_q];
	end

	// Right window as seen by the candidate now leaving memory
	always_comb begin
		rc[0] = win_q[0];
		rc[1] = win_q[1];
		rc[2] = rdata_s1;
		for (int k = 0; k < 3; k++) begin
			for (int r = 0; r < 3; r++) begin
				logic [PIX_W-1:0] a, b, d;
				a = lw_q[k][PIX_W*r +: PIX_W];
				b = rc[k][PIX_W*r +: PIX_W];
				d = (a > b) ? a - b : b - a;
				sq[3*k + r] = SQ_W'(d * d);
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int i = 0; i < 9; i++)
			sum = sum + SCORE_W'(sq_s2[i]);
	end

	// Payload registers of the scoring pipeline
	always_ff @(posedge clk) begin
		if (rv_s1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= rdata_s1;
		end
		if (win_full)
			sq_s2 <= sq;
		if (sqv_s2)
			sum_s3 <= sum;
	end

	// Control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q   <= WIDTH_RESET;
			max_search_q  <= SEARCH_RESET;
			cnt_q         <= '0;
			wp_q          <= '0;
			state_q       <= ST_IDLE;
			rd_addr_q     <= '0;
			fetch_left_q  <= '0;
			nm1_q         <= '0;
			cand_q        <= '0;
			fill_q        <= '0;
			rv_s1         <= 1'b0;
			sqv_s2        <= 1'b0;
			sv_s3         <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ROW_WIDTH:  row_width_q  <= cfg_data;
					CFG_MAX_SEARCH: max_search_q <= cfg_data[SRCH_W-1:0];
					default: ;
				endcase
			end

			if (accept) begin
				cnt_q <= (c_cur < COUNT_MAX) ? c_cur + CNT_W'(1) : COUNT_MAX;
				wp_q  <= (wp_cur == RW'(RING_DEPTH - 1)) ? '0 : wp_cur + RW'(1);
				if (has_result) begin
					rd_addr_q    <= start_addr;
					fetch_left_q <= FETCH_W'(nm1_cur) + FETCH_W'(3);
					nm1_q        <= nm1_cur;
					cand_q       <= '0;
					fill_q       <= '0;
				end
			end

			// Advance the read pointer around the ring
			rv_s1 <= fetch_en;
			if (fetch_en) begin
				rd_addr_q    <= (rd_addr_q == RW'(RING_DEPTH - 1)) ? '0 : rd_addr_q + RW'(1);
				fetch_left_q <= fetch_left_q - FETCH_W'(1);
			end
			if (rv_s1 && fill_q != 2'd3)
				fill_q <= fill_q + 2'd1;

			sqv_s2 <= win_full;
			sv_s3  <= sqv_s2;

			if (sv_s3)
				cand_q <= cand_q + CAND_W'(1);

			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Compare stage, column bookkeeping and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			lw_q[0] <= lw_q[1];
			lw_q[1] <= lw_q[2];
			lw_q[2] <= {left_bottom, left_mid, left_top};
			xcol_q  <= x_cur[XCOL_W-1:0];
			xlast_q <= (x_cur == w_eff - WIDTH_W'(4));
		end
		// Strict less-than keeps the earliest candidate on a tie
		if (sv_s3 && (cand_q == '0 || sum_s3 < best_q)) begin
			best_q     <= sum_s3;
			best_idx_q <= cand_q;
		end
		if (load_out) begin
			disp_q <= DISP_W'(nm1_q - best_idx_q);
			col_q  <= xcol_q;
			last_q <= xlast_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign disparity   = disp_q;
	assign column      = col_q;
	assign last_in_row = last_q;

`ifndef SYNTHESIS
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!rv_s1 && !sqv_s2 && !sv_s3))
		else $error("scoring pipeline busy while idle");

	a_cand_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sv_s3 |-> (cand_q <= nm1_q))
		else $error("candidate count past search range");

	a_hold_no_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD) |-> (fetch_left_q == '0))
		else $error("fetches left over at end of search");

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("result word lost");
`endif

endmodule
